### design/mrgt_pkg.sv
`default_nettype none

package mrgt_pkg;

    localparam int unsigned MRGT_MAX_PACKETS = 4096;

    localparam int unsigned CNT_W   = 13;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned BYTES_W = 48;
    localparam int unsigned MASK_W  = 64;
    localparam int unsigned OIDX_W  = 6;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [WORD_W-1:0]  STOP_MARK = 32'hFFFF_FFFF;
    localparam logic [BYTES_W-1:0] BYTE_MAX  = {BYTES_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

    // register map, word index
    localparam logic REG_EXPECTED = 1'b0;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_MASK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_STOP,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

### design/mrgt_bitmap.sv
`default_nettype none

module mrgt_bitmap #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [AW-1:0]              i_rd_addr,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [mrgt_pkg::MASK_W-1:0] i_wr_data,
    output      logic [mrgt_pkg::MASK_W-1:0] o_rd_data
);
    import mrgt_pkg::*;

    logic [MASK_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [MASK_W-1:0] r_rd_data;

    // entry reads as zero until first written after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/multicast_receive_gap_tracker.sv
// Receive gap tracker. Each request is one completed receive: a data request
// marks its sequence number in a received bitmap (64 words of 64 bits held in
// a one-port-read, one-port-write memory): the bitmap word is read when the
// request is accepted and written back in the update state. Failed and
// finished-state requests are dropped while idle. A STOP request gives the
// final acknowledgement when nothing is missing; otherwise it scans the bitmap
// one word per cycle while the output is not stalled, giving one missing mask
// per word with a gap, the last one flagged.
// The bitmap reads as all zeros after reset with no clearing pass.
`default_nettype none

module multicast_receive_gap_tracker #(
    parameter int unsigned MAX_PACKETS = mrgt_pkg::MRGT_MAX_PACKETS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mrgt_pkg::APB_AW-1:0]  paddr,
    input  wire logic [mrgt_pkg::APB_DW-1:0]  pwdata,
    output      logic [mrgt_pkg::APB_DW-1:0]  prdata,
    output      logic                         pready,

    input  wire logic                         i_in_valid,
    output      logic                         o_in_ready,
    input  wire logic                         i_completion_ok,
    input  wire logic [mrgt_pkg::WORD_W-1:0]  i_first_word,
    input  wire logic [mrgt_pkg::LEN_W-1:0]   i_payload_length,

    output      logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    output      logic                         o_kind,
    output      logic [mrgt_pkg::OIDX_W-1:0]  o_word_index,
    output      logic [mrgt_pkg::MASK_W-1:0]  o_missing_mask,
    output      logic [mrgt_pkg::BYTES_W-1:0] o_total_bytes,
    output      logic                         o_last
);
    import mrgt_pkg::*;

    localparam int unsigned NWORDS = (MAX_PACKETS + 63) / 64;
    localparam int unsigned WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned NW_W   = $clog2(NWORDS + 1);
    localparam logic [CNT_W-1:0] MAX_E = CNT_W'(MAX_PACKETS);

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_expected;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_stop_seen, n_stop_seen;
    logic               r_finished, n_finished;
    logic [BYTES_W-1:0] r_bytes, n_bytes;

    logic [WORD_W-1:0]  r_word;
    logic [LEN_W-1:0]   r_len;

    logic [NW_W-1:0]    r_rd_idx, n_rd_idx;
    logic               r_chk_v, n_chk_v;
    logic [WIDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic               r_pend_v, n_pend_v;
    logic [WIDX_W-1:0]  r_pend_idx, n_pend_idx;
    logic [MASK_W-1:0]  r_pend_mask, n_pend_mask;

    logic               r_out_valid, n_out_valid;
    logic               r_out_kind, n_out_kind;
    logic [OIDX_W-1:0]  r_out_widx, n_out_widx;
    logic [MASK_W-1:0]  r_out_mask, n_out_mask;
    logic [BYTES_W-1:0] r_out_bytes, n_out_bytes;
    logic               r_out_last, n_out_last;

    logic               mem_rd_en, mem_wr_en;
    logic [WIDX_W-1:0]  mem_rd_addr, mem_wr_addr;
    logic [MASK_W-1:0]  mem_wr_data, mem_rd_data;

    logic               in_acc, in_live, in_stop;
    logic [CNT_W-1:0]   e_now;
    logic [NW_W-1:0]    nw;
    logic               in_range, set_new, ack_upd, upd_go, push_ok;
    logic [MASK_W-1:0]  bit_sel;
    logic [CNT_W-1:0]   count_nx;
    logic [BYTES_W:0]   byte_sum;
    logic [BYTES_W-1:0] bytes_nx;
    logic               nothing_missing;
    logic [CNT_W-1:0]   rem;
    logic [MASK_W-1:0]  valid_mask, gaps;
    logic               hit, stall, scan_more, scan_done, scan_exit, stop_ack_go;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXPECTED) begin
            r_expected <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXPECTED) ? APB_DW'(r_expected) : '0;

    // shared terms
    assign e_now    = (r_expected > MAX_E) ? MAX_E : r_expected;
    assign nw       = NW_W'((e_now + CNT_W'(63)) >> 6);
    assign push_ok  = !r_out_valid || i_out_ready;

    assign in_acc   = i_in_valid && o_in_ready;
    assign in_live  = in_acc && i_completion_ok && !r_finished;
    assign in_stop  = i_first_word == STOP_MARK;

    assign in_range = r_word < WORD_W'(e_now);
    assign bit_sel  = MASK_W'(1) << r_word[5:0];
    assign set_new  = in_range && ((mem_rd_data & bit_sel) == '0);
    assign count_nx = (set_new && r_count != CNT_MAX) ? r_count + CNT_W'(1) : r_count;
    assign byte_sum = {1'b0, r_bytes} + (BYTES_W+1)'(r_len);
    assign bytes_nx = byte_sum[BYTES_W] ? BYTE_MAX : byte_sum[BYTES_W-1:0];
    assign ack_upd  = r_stop_seen && (count_nx >= e_now);
    assign upd_go   = !ack_upd || push_ok;

    assign nothing_missing = r_count >= e_now;
    assign stop_ack_go     = nothing_missing && push_ok;

    assign rem        = e_now - CNT_W'({r_chk_idx, 6'd0});
    assign valid_mask = (rem >= CNT_W'(64)) ? '1 : (MASK_W'(1) << rem[5:0]) - MASK_W'(1);
    assign gaps       = ~mem_rd_data & valid_mask;
    assign hit        = r_chk_v && (gaps != '0);
    assign stall      = hit && r_pend_v && !push_ok;
    assign scan_more  = r_rd_idx < nw;
    assign scan_done  = !r_chk_v && !scan_more;
    assign scan_exit  = scan_done && (!r_pend_v || push_ok);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_live) begin
                    n_state = in_stop ? S_STOP : S_UPD;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            S_STOP: begin
                if (!nothing_missing) begin
                    n_state = S_SCAN;
                end else if (stop_ack_go) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_exit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        o_in_ready  = r_state == S_IDLE;
        n_count     = r_count;
        n_stop_seen = r_stop_seen;
        n_finished  = r_finished;
        n_bytes     = r_bytes;
        n_rd_idx    = r_rd_idx;
        n_chk_v     = r_chk_v;
        n_chk_idx   = r_chk_idx;
        n_pend_v    = r_pend_v;
        n_pend_idx  = r_pend_idx;
        n_pend_mask = r_pend_mask;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_widx  = r_out_widx;
        n_out_mask  = r_out_mask;
        n_out_bytes = r_out_bytes;
        n_out_last  = r_out_last;
        mem_rd_en   = 1'b0;
        mem_rd_addr = i_first_word[WIDX_W+5:6];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_word[WIDX_W+5:6];
        mem_wr_data = mem_rd_data | bit_sel;

        case (r_state)
            S_IDLE: begin
                mem_rd_en = in_live && !in_stop;
            end
            S_UPD: begin
                if (upd_go) begin
                    mem_wr_en = set_new;
                    n_count   = count_nx;
                    n_bytes   = bytes_nx;
                    if (ack_upd) begin
                        n_finished  = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_ACK;
                        n_out_widx  = '0;
                        n_out_mask  = '0;
                        n_out_bytes = bytes_nx;
                        n_out_last  = 1'b1;
                    end
                end
            end
            S_STOP: begin
                n_stop_seen = 1'b1;
                if (!nothing_missing) begin
                    n_rd_idx = '0;
                    n_chk_v  = 1'b0;
                    n_pend_v = 1'b0;
                end else if (stop_ack_go) begin
                    n_finished  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_ACK;
                    n_out_widx  = '0;
                    n_out_mask  = '0;
                    n_out_bytes = r_bytes;
                    n_out_last  = 1'b1;
                end
            end
            S_SCAN: begin
                mem_rd_addr = r_rd_idx[WIDX_W-1:0];
                if (scan_done) begin
                    if (r_pend_v && push_ok) begin
                        n_pend_v    = 1'b0;
                        n_out_valid = 1'b1;
                        n_out_kind  = KIND_MASK;
                        n_out_widx  = OIDX_W'(r_pend_idx);
                        n_out_mask  = r_pend_mask;
                        n_out_bytes = r_bytes;
                        n_out_last  = 1'b1;
                    end
                end else if (!stall) begin
                    if (hit) begin
                        if (r_pend_v) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_MASK;
                            n_out_widx  = OIDX_W'(r_pend_idx);
                            n_out_mask  = r_pend_mask;
                            n_out_bytes = r_bytes;
                            n_out_last  = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_idx  = r_chk_idx;
                        n_pend_mask = gaps;
                    end
                    if (scan_more) begin
                        mem_rd_en = 1'b1;
                        n_rd_idx  = r_rd_idx + NW_W'(1);
                        n_chk_v   = 1'b1;
                        n_chk_idx = r_rd_idx[WIDX_W-1:0];
                    end else begin
                        n_chk_v = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_stop_seen <= 1'b0;
            r_finished  <= 1'b0;
            r_bytes     <= '0;
            r_rd_idx    <= '0;
            r_chk_v     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_stop_seen <= n_stop_seen;
            r_finished  <= n_finished;
            r_bytes     <= n_bytes;
            r_rd_idx    <= n_rd_idx;
            r_chk_v     <= n_chk_v;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= i_first_word;
            r_len  <= i_payload_length;
        end
        r_chk_idx   <= n_chk_idx;
        r_pend_idx  <= n_pend_idx;
        r_pend_mask <= n_pend_mask;
        r_out_kind  <= n_out_kind;
        r_out_widx  <= n_out_widx;
        r_out_mask  <= n_out_mask;
        r_out_bytes <= n_out_bytes;
        r_out_last  <= n_out_last;
    end

    mrgt_bitmap #(
        .DEPTH (NWORDS),
        .AW    (WIDX_W)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_word_index   = r_out_widx;
    assign o_missing_mask = r_out_mask;
    assign o_total_bytes  = r_out_bytes;
    assign o_last         = r_out_last;

    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped");

    a_ack_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ACK) |-> r_finished)
        else $error("acknowledgement without finish");

    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_ACK) |-> (o_last && o_missing_mask == '0))
        else $error("malformed acknowledgement");

    a_scan_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_stop_seen && !r_finished))
        else $error("scan without stop");

    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_MASK) |-> (o_missing_mask != '0))
        else $error("empty missing mask");

endmodule

`default_nettype wire
